### rtl/core/dueg_pkg.sv
// ----------------------------------------------------------------------------
// dueg_pkg
// Shared widths, fixed-point constants and types for the DFT+U energy and
// gradient engine.
// ----------------------------------------------------------------------------
package dueg_pkg;

  localparam int DUEG_MAX_L = 3;

  localparam int ELEM_W    = 32;
  localparam int U_W       = 32;
  localparam int L_W       = 2;
  localparam int GRAD_W    = 48;
  localparam int IDX_W     = 6;
  localparam int ENERGY_W  = 64;
  localparam int TRACE_W   = 40;

  localparam int FRAC_BITS = 28;

  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int WIDE_W    = 98;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_opnd_t;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_DRAIN  = 9'b000000010,
    ST_DIFF   = 9'b000000100,
    ST_MLO    = 9'b000001000,
    ST_MHI    = 9'b000010000,
    ST_ESUM   = 9'b000100000,
    ST_ETRUNC = 9'b001000000,
    ST_EACC   = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

endpackage

### rtl/core/dueg_mul.sv
// ----------------------------------------------------------------------------
// dueg_mul
// Shared signed multiplier with a registered product, used for the matrix
// products, the split energy product and the gradient elements.
// ----------------------------------------------------------------------------
module dueg_mul import dueg_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  mul_opnd_t                opnd,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= opnd.a * opnd.b;
    end
  end

endmodule

### rtl/core/dft_u_energy_gradient.sv
// ----------------------------------------------------------------------------
// dft_u_energy_gradient
// Dudarev DFT+U energy and gradient engine, one occupation block at a time.
// ----------------------------------------------------------------------------
// A block of s = (2l+1)^2 occupation elements is taken one element per cycle
// in row-major order; the first element also carries U, l and new_sum. The
// elements go into a one-read, one-write matrix memory while the trace and,
// through the shared multiplier, Tr(nn) build up. After the last element the
// block drains the product pipeline and forms the energy term (two passes
// through the multiplier for the 64x32 product), then streams the s gradient
// elements one per cycle through the memory read, multiplier and output
// registers, holding while grad_stall is high. No element is taken while
// results of the block are still being delivered. The memory needs no
// clearing after reset: only entries written earlier in the same block are
// used.
// ----------------------------------------------------------------------------
module dft_u_energy_gradient import dueg_pkg::*; #(
  parameter int MAX_L = DUEG_MAX_L
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       elem_valid,
  output logic                       elem_stall,
  input  logic signed [ELEM_W-1:0]   elem,
  input  logic signed [U_W-1:0]      u_value,
  input  logic [L_W-1:0]             l_value,
  input  logic                       new_sum,
  output logic                       grad_valid,
  input  logic                       grad_stall,
  output logic signed [GRAD_W-1:0]   grad_elem,
  output logic [IDX_W-1:0]           elem_index,
  output logic signed [ENERGY_W-1:0] energy_total,
  output logic                       last
);

  localparam int N_MAX = 2 * MAX_L + 1;
  localparam int DEPTH = N_MAX * N_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int GS    = FRAC_BITS - 8;
  localparam int SQS   = 2 * FRAC_BITS - 32;
  localparam int TRS   = 32 - FRAC_BITS;

  localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic signed [GRAD_W-1:0]   G_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0]   G_MIN = {1'b1, {(GRAD_W-1){1'b0}}};
  localparam logic signed [MUL_W-1:0]    HALF  = MUL_W'(1) <<< (FRAC_BITS - 1);

  function automatic logic [L_W-1:0] clamp_l(input logic [L_W-1:0] l);
    return (l > L_W'(MAX_L)) ? L_W'(MAX_L) : l;
  endfunction

  function automatic logic [RW-1:0] nm1_of(input logic [L_W-1:0] l);
    return RW'({clamp_l(l), 1'b0});
  endfunction

  function automatic logic [AW-1:0] last_of(input logic [L_W-1:0] l);
    logic [AW-1:0] r;
    unique case (clamp_l(l))
      2'd0:    r = AW'(0);
      2'd1:    r = AW'(8);
      2'd2:    r = AW'(24);
      default: r = AW'(48);
    endcase
    return r;
  endfunction

  function automatic logic signed [ENERGY_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-ENERGY_W:0] top;
    top = v[WIDE_W-1:ENERGY_W-1];
    if ((&top) || !(|top)) begin
      return v[ENERGY_W-1:0];
    end
    return v[WIDE_W-1] ? E_MIN : E_MAX;
  endfunction

  state_t state, state_next;

  logic [RW-1:0] row, col, nm1, cur_nm1, row_inc;
  logic [AW-1:0] cnt, taddr, last_idx, cur_last;
  logic          first, elem_acc, issue, step, adv, issue_done;

  logic signed [U_W-1:0]      block_u;
  logic signed [TRACE_W-1:0]  trace_acc;
  logic signed [ENERGY_W-1:0] sq_acc, energy_acc, diff, term;
  logic signed [PROD_W-1:0]   plo, prod;
  logic signed [WIDE_W-1:0]   full;

  logic signed [ELEM_W-1:0] matrix_store [DEPTH];
  logic signed [ELEM_W-1:0] rdata;

  logic                     ld_v1, ld_v2, em_v1, em_v2;
  logic                     diag1, lower1, diag2, lower2, last1, last2;
  logic signed [ELEM_W-1:0] x1;
  logic [AW-1:0]            idx1, idx2;

  mul_opnd_t                opnd;
  logic signed [MUL_W-1:0]  gv;
  logic signed [PROD_W-1:0] sq_p, sq_sum, gq, gq_adj;
  logic [PROD_W-GRAD_W:0]   gtop;
  logic signed [GRAD_W-1:0] gsat;
  logic signed [ENERGY_W-1:0] sq_next, diff_next, term_next, energy_next;
  logic signed [WIDE_W-1:0] eq, eq_adj;

  // Control.
  assign elem_stall = (state != ST_LOAD);
  assign elem_acc   = elem_valid && !elem_stall;
  assign adv        = !grad_valid || !grad_stall;
  assign issue      = (state == ST_EMIT) && !issue_done && adv;
  assign step       = elem_acc || issue;
  assign first      = (state == ST_LOAD) && (cnt == '0);
  assign cur_nm1    = first ? nm1_of(l_value) : nm1;
  assign cur_last   = first ? last_of(l_value) : last_idx;
  assign row_inc    = RW'(row + 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:   if (elem_acc && (cnt == cur_last)) state_next = ST_DRAIN;
      ST_DRAIN:  if (!ld_v1 && !ld_v2) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_MLO;
      ST_MLO:    state_next = ST_MHI;
      ST_MHI:    state_next = ST_ESUM;
      ST_ESUM:   state_next = ST_ETRUNC;
      ST_ETRUNC: state_next = ST_EACC;
      ST_EACC:   state_next = ST_EMIT;
      ST_EMIT:   if (grad_valid && !grad_stall && last) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Row, column and transposed address walk, shared by load and emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      col   <= '0;
      cnt   <= '0;
      taddr <= '0;
    end else if (step) begin
      if (cnt == cur_last) begin
        row   <= '0;
        col   <= '0;
        cnt   <= '0;
        taddr <= '0;
      end else begin
        cnt <= AW'(cnt + 1'b1);
        if (col == cur_nm1) begin
          col   <= '0;
          row   <= row_inc;
          taddr <= AW'(row_inc);
        end else begin
          col   <= RW'(col + 1'b1);
          taddr <= AW'(taddr + cur_nm1 + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_done <= 1'b0;
    end else if (state == ST_EACC) begin
      issue_done <= 1'b0;
    end else if (issue && (cnt == last_idx)) begin
      issue_done <= 1'b1;
    end
  end

  // Block parameters.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_u  <= '0;
      nm1      <= '0;
      last_idx <= '0;
    end else if (elem_acc && first) begin
      block_u  <= u_value;
      nm1      <= nm1_of(l_value);
      last_idx <= last_of(l_value);
    end
  end

  // Matrix memory.
  always_ff @(posedge clk) begin
    if (elem_acc) begin
      matrix_store[cnt] <= elem;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rdata <= matrix_store[taddr];
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v1      <= 1'b0;
      ld_v2      <= 1'b0;
      em_v1      <= 1'b0;
      em_v2      <= 1'b0;
      grad_valid <= 1'b0;
    end else if (adv) begin
      ld_v1      <= elem_acc;
      ld_v2      <= ld_v1;
      em_v1      <= issue;
      em_v2      <= em_v1;
      grad_valid <= em_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= elem;
      diag1  <= (row == col);
      lower1 <= (col < row);
      idx1   <= cnt;
      last1  <= (cnt == cur_last);
      diag2  <= diag1;
      lower2 <= lower1;
      idx2   <= idx1;
      last2  <= last1;
      if (em_v2) begin
        grad_elem  <= gsat;
        elem_index <= IDX_W'(idx2);
        last       <= last2;
      end
    end
  end

  // Multiplier operands.
  assign gv = (diag1 ? HALF : MUL_W'(0)) - MUL_W'(rdata);

  always_comb begin
    if (ld_v1) begin
      opnd.a = MUL_W'(x1);
      opnd.b = diag1 ? MUL_W'(x1) : MUL_W'(rdata);
    end else if (em_v1) begin
      opnd.a = gv;
      opnd.b = MUL_W'(block_u);
    end else if (state == ST_MHI) begin
      opnd.a = MUL_W'($signed(diff[ENERGY_W-1:32]));
      opnd.b = MUL_W'(block_u);
    end else begin
      opnd.a = {1'b0, diff[31:0]};
      opnd.b = MUL_W'(block_u);
    end
  end

  dueg_mul u_mul (
    .clk  (clk),
    .en   (adv),
    .opnd (opnd),
    .prod (prod)
  );

  // Trace and Tr(nn).
  assign sq_p    = prod >>> SQS;
  assign sq_sum  = PROD_W'(sq_acc) + (lower2 ? (sq_p <<< 1) : sq_p);
  assign sq_next = sat64(WIDE_W'(sq_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_acc <= '0;
      sq_acc    <= '0;
    end else begin
      if (elem_acc && (row == col)) begin
        trace_acc <= first ? TRACE_W'(elem) : TRACE_W'(trace_acc + TRACE_W'(elem));
      end
      if (elem_acc && first) begin
        sq_acc <= '0;
      end else if (ld_v2 && (diag2 || lower2)) begin
        sq_acc <= sq_next;
      end
    end
  end

  // Energy term.
  assign diff_next = sat64(WIDE_W'((PROD_W'(trace_acc) <<< TRS)
                     + ((sq_acc == E_MIN) ? PROD_W'(E_MAX) : -PROD_W'(sq_acc))));
  assign eq        = full >>> 25;
  assign eq_adj    = eq + $signed({{(WIDE_W-1){1'b0}}, full[WIDE_W-1] && (|full[24:0])});
  assign term_next = sat64(eq_adj);
  assign energy_next = sat64(WIDE_W'(energy_acc) + WIDE_W'(term));

  always_ff @(posedge clk) begin
    if (state == ST_DIFF) begin
      diff <= diff_next;
    end
    if (state == ST_MHI) begin
      plo <= prod;
    end
    if (state == ST_ESUM) begin
      full <= (WIDE_W'(prod) <<< 32) + WIDE_W'(plo);
    end
    if (state == ST_ETRUNC) begin
      term <= term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc <= '0;
    end else if (elem_acc && first && new_sum) begin
      energy_acc <= '0;
    end else if (state == ST_EACC) begin
      energy_acc <= energy_next;
    end
  end

  assign energy_total = energy_acc;

  // Gradient rounding toward zero and saturation.
  assign gq     = prod >>> GS;
  assign gq_adj = gq + $signed({{(PROD_W-1){1'b0}}, prod[PROD_W-1] && (|prod[GS-1:0])});
  assign gtop   = gq_adj[PROD_W-1:GRAD_W-1];
  assign gsat   = ((&gtop) || !(|gtop)) ? gq_adj[GRAD_W-1:0]
                                        : (gq_adj[PROD_W-1] ? G_MIN : G_MAX);

endmodule

### rtl/core/dueg_chk.sv
// ----------------------------------------------------------------------------
// dueg_chk
// Port-level checks for the DFT+U energy and gradient engine, bound to the
// top level.
// ----------------------------------------------------------------------------
module dueg_chk import dueg_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       elem_stall,
  input logic                       grad_valid,
  input logic                       grad_stall,
  input logic signed [GRAD_W-1:0]   grad_elem,
  input logic [IDX_W-1:0]           elem_index,
  input logic signed [ENERGY_W-1:0] energy_total,
  input logic                       last
);

  a_grad_hold: assert property (@(posedge clk) disable iff (rst)
    grad_valid && grad_stall |=> grad_valid && $stable(grad_elem)
                                 && $stable(elem_index) && $stable(last))
    else $error("grad request changed while stalled");

  a_no_load_during_emit: assert property (@(posedge clk) disable iff (rst)
    grad_valid |-> elem_stall)
    else $error("element request open while results pending");

  a_energy_steady: assert property (@(posedge clk) disable iff (rst)
    grad_valid && $past(grad_valid) |-> $stable(energy_total))
    else $error("energy total moved inside a block");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    grad_valid && last |-> elem_index == 6'd0 || elem_index == 6'd8
                           || elem_index == 6'd24 || elem_index == 6'd48)
    else $error("last flag on a non-final index");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    grad_valid && !grad_stall && last |=> !grad_valid)
    else $error("result after the final element of a block");

endmodule

bind dft_u_energy_gradient dueg_chk u_dueg_chk (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Dudarev DFT+U energy and gradient engine. It
// streams occupation blocks of every size and predicts each gradient element,
// its index, the running energy sum and the end-of-block flag. Each delivered
// result is checked against the oldest prediction. The bench cycles through
// sender gaps and receiver stalls, and holds off the receiver for a long
// stretch so that the engine stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import dueg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] MAX64 = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
  localparam int NUM_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [ELEM_W-1:0] elem;
    logic signed [U_W-1:0]    u;
    logic [L_W-1:0]           l;
    logic                     ns;
  } occ_item_t;

  typedef struct {
    logic signed [GRAD_W-1:0]   grad;
    logic [IDX_W-1:0]           idx;
    logic signed [ENERGY_W-1:0] energy;
    logic                       last;
  } grad_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       elem_valid = 1'b0;
  logic                       elem_stall;
  logic signed [ELEM_W-1:0]   elem = '0;
  logic signed [U_W-1:0]      u_value = '0;
  logic [L_W-1:0]             l_value = '0;
  logic                       new_sum = 1'b0;
  logic                       grad_valid;
  logic                       grad_stall = 1'b0;
  logic signed [GRAD_W-1:0]   grad_elem;
  logic [IDX_W-1:0]           elem_index;
  logic signed [ENERGY_W-1:0] energy_total;
  logic                       last;

  occ_item_t    occupation_q[$];
  occ_item_t    cur_item;
  grad_result_t pending_grads[$];
  grad_result_t want;
  int           accepted = 0;
  int           mismatches = 0;
  logic         hold_off = 1'b0;

  logic signed [ELEM_W-1:0] occ_store [49];
  int                       occ_count = 0;
  logic signed [63:0]       trace_sum = '0;
  logic signed [63:0]       nn_sum = '0;
  logic signed [63:0]       energy_sum = '0;
  logic signed [U_W-1:0]    blk_u = '0;
  int                       blk_l = 0;

  dft_u_energy_gradient u_dut (
    .clk          (clk),
    .rst          (rst),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .elem         (elem),
    .u_value      (u_value),
    .l_value      (l_value),
    .new_sum      (new_sum),
    .grad_valid   (grad_valid),
    .grad_stall   (grad_stall),
    .grad_elem    (grad_elem),
    .elem_index   (elem_index),
    .energy_total (energy_total),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      return s[64] ? MIN64 : MAX64;
    end
    return s[63:0];
  endfunction

  // (a*b) >> s toward zero, saturated to [-maxv-1, maxv]
  function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                        logic signed [31:0] b,
                                                        int s,
                                                        logic [63:0] maxv);
    logic signed [127:0] p;
    logic [127:0]        mag;
    logic [127:0]        lim;
    logic                neg;
    p = a;
    p = p * b;
    neg = p < 0;
    mag = neg ? -p : p;
    mag = mag >> s;
    lim = {64'd0, maxv} + neg;
    if (mag > lim) begin
      mag = lim;
    end
    return neg ? -mag[63:0] : mag[63:0];
  endfunction

  task automatic dudarev_step(occ_item_t it);
    int                 n;
    int                 sz;
    int                 row;
    int                 col;
    int                 i;
    int                 j;
    logic signed [63:0] x;
    logic signed [63:0] prod;
    logic signed [63:0] d;
    logic signed [63:0] v;
    logic signed [63:0] g;
    grad_result_t       r;
    if (occ_count == 0) begin
      blk_l = it.l;
      blk_u = it.u;
      if (it.ns) begin
        energy_sum = '0;
      end
      trace_sum = '0;
      nn_sum = '0;
    end
    n = 2 * blk_l + 1;
    sz = n * n;
    row = occ_count / n;
    col = occ_count % n;
    x = it.elem;
    occ_store[occ_count] = it.elem;
    if (row == col) begin
      trace_sum = trace_sum + x;
      prod = x * x;
      nn_sum = sat_sum(nn_sum, prod >>> (2 * FRAC_BITS - 32));
    end else if (col < row) begin
      prod = x * occ_store[col * n + row];
      prod = prod >>> (2 * FRAC_BITS - 32);
      nn_sum = sat_sum(sat_sum(nn_sum, prod), prod);
    end
    occ_count++;
    if (occ_count < sz) begin
      return;
    end
    occ_count = 0;
    if (blk_u != 0) begin
      d = sat_sum(trace_sum <<< (32 - FRAC_BITS), (nn_sum == MIN64) ? MAX64 : -nn_sum);
      energy_sum = sat_sum(energy_sum, scaled_product(d, blk_u, 25, MAX64));
    end
    for (int k = 0; k < sz; k++) begin
      i = k / n;
      j = k % n;
      g = '0;
      if (blk_u != 0) begin
        v = (i == j) ? (64'sd1 <<< (FRAC_BITS - 1)) : 64'sd0;
        v = v - occ_store[j * n + i];
        g = scaled_product(v, blk_u, FRAC_BITS - 8, MAX48);
      end
      r.grad = g[GRAD_W-1:0];
      r.idx = IDX_W'(k);
      r.energy = energy_sum;
      r.last = (k == sz - 1);
      pending_grads.push_back(r);
    end
  endtask

  function automatic logic signed [31:0] rand_occupation();
    logic [31:0] picks [4];
    picks = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(32'h1000_0000, 0);
      4:          return -$signed($urandom_range(32'h0200_0000, 0));
      5, 6, 7:    return $urandom;
      8:          return picks[$urandom_range(3)];
      default:    return $signed($urandom_range(32'h0400_0000, 0)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_hubbard();
    logic [31:0] picks [4];
    picks = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff};
    case ($urandom_range(9))
      0:                return '0;
      1:                return picks[$urandom_range(3)];
      2, 3, 4, 5, 6:    return $urandom_range(32'h0a00_0000, 0);
      default:          return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [31:0] e, logic [31:0] u, int l, logic ns);
    occ_item_t it;
    it.elem = e;
    it.u = u;
    it.l = L_W'(l);
    it.ns = ns;
    occupation_q.push_back(it);
  endtask

  // mid-block u, l and new_sum are noise
  task automatic queue_block(int l, logic [31:0] u, logic ns);
    int n;
    n = (2 * l + 1) * (2 * l + 1);
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        add_item(rand_occupation(), u, l, ns);
      end else begin
        add_item(rand_occupation(), $urandom, $urandom_range(3), 1'($urandom_range(1)));
      end
    end
  endtask

  function automatic int idle_mode();
    if (accepted < 70) begin
      return 0;
    end
    return ((accepted - 70) / 25) % 4;
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode())
      1:       return 88;
      3:       return 31;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode())
      2:       return 88;
      3:       return 31;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else begin
      if (elem_valid && !elem_stall) begin
        dudarev_step(cur_item);
        accepted++;
      end
      if (!elem_valid || !elem_stall) begin
        if (occupation_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_item = occupation_q.pop_front();
          elem <= cur_item.elem;
          u_value <= cur_item.u;
          l_value <= cur_item.l;
          new_sum <= cur_item.ns;
          elem_valid <= 1'b1;
        end else begin
          elem_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string fld, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t mismatch %s expected %h actual %h", $time, fld, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grad_stall <= 1'b0;
    end else begin
      grad_stall <= hold_off || ($urandom_range(99) < recv_stall_pct());
      if (grad_valid && !grad_stall) begin
        if (pending_grads.size() == 0) begin
          $display("%0t unexpected result expected none actual index %0d grad %h",
                   $time, elem_index, grad_elem);
          mismatches++;
        end else begin
          want = pending_grads.pop_front();
          if (grad_elem !== want.grad) begin
            report_field("grad_elem", want.grad, grad_elem);
          end
          if (elem_index !== want.idx) begin
            report_field("elem_index", want.idx, elem_index);
          end
          if (energy_total !== want.energy) begin
            report_field("energy_total", want.energy, energy_total);
          end
          if (last !== want.last) begin
            report_field("last", want.last, last);
          end
        end
      end
    end
  end

  // hold off the receiver while the sender keeps offering
  initial begin
    wait (!rst && accepted >= 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [31:0] dir_elems [9];
    bit          big_done;
    dir_elems = '{32'h7fff_ffff, 32'h8000_0000, 32'h1000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                  32'h8000_0000};
    add_item(32'h7fff_ffff, 32'h7fff_ffff, 0, 1'b1);
    add_item(32'h8000_0000, 32'h8000_0000, 0, 1'b0);
    add_item(32'h8000_0000, 32'h7fff_ffff, 0, 1'b0);
    add_item(32'h1000_0000, 32'h0000_0000, 0, 1'b0);
    add_item(32'h0000_0000, 32'h0000_0001, 0, 1'b1);
    add_item(32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
    for (int k = 0; k < 9; k++) begin
      if (k == 0) begin
        add_item(dir_elems[k], 32'h0400_0000, 1, 1'b1);
      end else begin
        add_item(dir_elems[k], $urandom, 3, 1'b1);
      end
    end
    big_done = 0;
    while (occupation_q.size() < NUM_ITEMS) begin
      if (!big_done && occupation_q.size() >= 60) begin
        queue_block(3, rand_hubbard(), 1'($urandom_range(1)));
        big_done = 1;
      end else begin
        case ($urandom_range(9))
          0, 1, 2:    queue_block(0, rand_hubbard(), 1'($urandom_range(1)));
          3, 4, 5, 6: queue_block(1, rand_hubbard(), 1'($urandom_range(1)));
          default:    queue_block(2, rand_hubbard(), 1'($urandom_range(1)));
        endcase
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (occupation_q.size() != 0 || elem_valid || pending_grads.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
